// File: rtl/core/pl_pkg.sv
`timescale 1ns / 1ps

package pl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width for position arithmetic: wide enough for the 5-bit position,
    // the count and one more.
    localparam int PW       = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        REQ_ADD_HEAD = 3'd0,
        REQ_ADD_TAIL = 3'd1,
        REQ_INSERT   = 3'd2,
        REQ_REM_HEAD = 3'd3,
        REQ_REM_TAIL = 3'd4,
        REQ_REM_POS  = 3'd5,
        REQ_SEARCH   = 3'd6,
        REQ_DUMP     = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_PROBE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    idx;
        logic [CNT_W-1:0]    cnt;
        logic [DATA_W-1:0]   key;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESP,
        ST_DUMP
    } state_t;

endpackage

// File: rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                                  Transfer
// request   in         start, busy, req_type, value, position start & !busy
// result    out        done, status, data, found, last, count done (one cycle, no stall)
//
// Every request other than a nonempty dump passes through the RESP state after
// acceptance and gives its result as it leaves it; busy is high while in RESP.
// A nonempty dump keeps busy high while the cell ring rotates once.
// Its results are registered from the last cell as the ring rotates, tail first, and the final
// one arrives in the same cycle as busy falls.
// Reset clears the count and the controller; cell contents are left as they are.
// Results cannot be held off, so nothing ever waits on the result side.

module positional_list_engine
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         req_type,
    input  logic signed [pl_pkg::DATA_W-1:0]   value,
    input  logic [4:0]                         position,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [pl_pkg::DATA_W-1:0]   data,
    output logic                               found,
    output logic                               last,
    output logic [4:0]                         count
);

    pl_pkg::state_t              state_reg;
    pl_pkg::state_t              state_next;
    logic [pl_pkg::CNT_W-1:0]    cnt_reg;
    logic [pl_pkg::CNT_W-1:0]    cnt_next;
    logic [pl_pkg::IDX_W-1:0]    step_reg;
    logic [pl_pkg::IDX_W-1:0]    step_next;
    pl_pkg::stat_t               pend_reg;
    pl_pkg::stat_t               pend_next;
    logic                        done_reg;
    logic                        done_next;
    pl_pkg::stat_t               status_reg;
    pl_pkg::stat_t               status_next;
    logic [pl_pkg::DATA_W-1:0]   data_reg;
    logic [pl_pkg::DATA_W-1:0]   data_next;
    logic                        found_reg;
    logic                        found_next;
    logic                        last_reg;
    logic                        last_next;

    pl_pkg::cell_cmd_t           cmd;
    pl_pkg::req_t                req;
    logic                        accept;
    logic                        full;
    logic                        empty;
    logic [pl_pkg::PW-1:0]       pos_w;
    logic [pl_pkg::PW-1:0]       cnt_w;
    logic [pl_pkg::PW-1:0]       ins_p;
    logic                        emit;
    logic                        step_end;
    logic [pl_pkg::DATA_W-1:0]   tail;
    logic [pl_pkg::DATA_W-1:0]   tap_any;
    logic                        hit_any;
    logic [31:0]                 cnt_wide;

    assign req      = pl_pkg::req_t'(req_type);
    assign accept   = start && (state_reg == pl_pkg::ST_IDLE);
    assign full     = (cnt_reg == pl_pkg::CNT_W'(pl_pkg::CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign pos_w    = pl_pkg::PW'(position);
    assign cnt_w    = pl_pkg::PW'(cnt_reg);
    assign step_end = (step_reg == pl_pkg::IDX_W'(pl_pkg::CAPACITY - 1));
    // After step_reg rotations the last cell holds an element once step + count
    // reaches the capacity.
    assign emit     = (pl_pkg::PW'(step_reg) + cnt_w) >= pl_pkg::PW'(pl_pkg::CAPACITY);

    always_comb
    begin
        ins_p = (pos_w == '0) ? pl_pkg::PW'(1) : pos_w;
        if (ins_p > cnt_w + 1'b1)
        begin
            ins_p = cnt_w + 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req == pl_pkg::REQ_DUMP && !empty)
                    begin
                        state_next = pl_pkg::ST_DUMP;
                    end
                    else
                    begin
                        state_next = pl_pkg::ST_RESP;
                    end
                end
            end
            pl_pkg::ST_RESP:
            begin
                state_next = pl_pkg::ST_IDLE;
            end
            pl_pkg::ST_DUMP:
            begin
                if (step_end)
                begin
                    state_next = pl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pl_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell commands, count, and result registers.
    always_comb
    begin
        cmd.op      = pl_pkg::CELL_HOLD;
        cmd.idx     = '0;
        cmd.cnt     = cnt_reg;
        cmd.key     = value;
        cnt_next    = cnt_reg;
        step_next   = '0;
        pend_next   = pend_reg;
        done_next   = 1'b0;
        status_next = pl_pkg::STAT_OK;
        data_next   = '0;
        found_next  = 1'b0;
        last_next   = 1'b1;
        case (state_reg)
            pl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = pl_pkg::STAT_OK;
                    case (req)
                        pl_pkg::REQ_ADD_HEAD, pl_pkg::REQ_ADD_TAIL, pl_pkg::REQ_INSERT:
                        begin
                            if (full)
                            begin
                                pend_next = pl_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cmd.op   = pl_pkg::CELL_INSERT;
                                cnt_next = cnt_reg + 1'b1;
                                if (req == pl_pkg::REQ_ADD_TAIL)
                                begin
                                    cmd.idx = pl_pkg::IDX_W'(cnt_reg);
                                end
                                else if (req == pl_pkg::REQ_INSERT)
                                begin
                                    cmd.idx = pl_pkg::IDX_W'(ins_p - 1'b1);
                                end
                            end
                        end
                        pl_pkg::REQ_REM_HEAD, pl_pkg::REQ_REM_TAIL, pl_pkg::REQ_REM_POS:
                        begin
                            if (empty)
                            begin
                                pend_next = pl_pkg::STAT_EMPTY;
                            end
                            else if (req == pl_pkg::REQ_REM_POS
                                     && (pos_w == '0 || pos_w > cnt_w))
                            begin
                                pend_next = pl_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cmd.op   = pl_pkg::CELL_REMOVE;
                                cnt_next = cnt_reg - 1'b1;
                                if (req == pl_pkg::REQ_REM_TAIL)
                                begin
                                    cmd.idx = pl_pkg::IDX_W'(cnt_w - 1'b1);
                                end
                                else if (req == pl_pkg::REQ_REM_POS)
                                begin
                                    cmd.idx = pl_pkg::IDX_W'(pos_w - 1'b1);
                                end
                            end
                        end
                        pl_pkg::REQ_SEARCH:
                        begin
                            cmd.op = pl_pkg::CELL_PROBE;
                            if (empty)
                            begin
                                pend_next = pl_pkg::STAT_EMPTY;
                            end
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                pend_next = pl_pkg::STAT_EMPTY;
                            end
                        end
                    endcase
                end
            end
            pl_pkg::ST_RESP:
            begin
                done_next   = 1'b1;
                status_next = pend_reg;
                data_next   = tap_any;
                found_next  = hit_any;
            end
            pl_pkg::ST_DUMP:
            begin
                cmd.op      = pl_pkg::CELL_ROTATE;
                step_next   = step_reg + 1'b1;
                done_next   = emit;
                data_next   = tail;
                last_next   = step_end;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    pl_chain u_chain
    (
        .clk     (clk),
        .cmd     (cmd),
        .tail    (tail),
        .tap_any (tap_any),
        .hit_any (hit_any)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pl_pkg::ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= '0;
            pend_reg  <= pl_pkg::STAT_OK;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    assign cnt_wide = 32'(cnt_reg);
    assign busy     = (state_reg != pl_pkg::ST_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data     = data_reg;
    assign found    = found_reg;
    assign last     = last_reg;
    assign count    = cnt_wide[4:0];

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pl_pkg::CNT_W'(pl_pkg::CAPACITY))
        else $error("list count exceeds capacity");

    a_cnt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != pl_pkg::ST_IDLE |=> cnt_reg == $past(cnt_reg))
        else $error("count changed while a request was in progress");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type != pl_pkg::REQ_DUMP |-> ##2 (done && last))
        else $error("single-result request did not complete on time");

    a_partial_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |-> state_reg == pl_pkg::ST_DUMP)
        else $error("non-final result outside a dump");

endmodule

// File: rtl/core/pl_cell.sv
`timescale 1ns / 1ps

module pl_cell
(
    input  logic                             clk,
    input  logic [pl_pkg::IDX_W-1:0]         index,
    input  pl_pkg::cell_cmd_t                cmd,
    input  logic [pl_pkg::DATA_W-1:0]        left_val,
    input  logic [pl_pkg::DATA_W-1:0]        right_val,
    output logic [pl_pkg::DATA_W-1:0]        val,
    output logic [pl_pkg::DATA_W-1:0]        tap,
    output logic                             hit
);

    logic [pl_pkg::DATA_W-1:0] val_reg;
    logic [pl_pkg::DATA_W-1:0] val_next;
    logic [pl_pkg::DATA_W-1:0] tap_reg;
    logic [pl_pkg::DATA_W-1:0] tap_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [pl_pkg::CNT_W-1:0]  pos_c;
    logic [pl_pkg::CNT_W-1:0]  idx_c;

    assign pos_c = pl_pkg::CNT_W'(index);
    assign idx_c = pl_pkg::CNT_W'(cmd.idx);

    always_comb
    begin
        val_next = val_reg;
        tap_next = '0;
        hit_next = 1'b0;
        case (cmd.op)
            pl_pkg::CELL_INSERT:
            begin
                if (pos_c == idx_c)
                begin
                    val_next = cmd.key;
                end
                else if (pos_c > idx_c && pos_c <= cmd.cnt)
                begin
                    val_next = left_val;
                end
            end
            pl_pkg::CELL_REMOVE:
            begin
                if (pos_c >= idx_c && pos_c + 1'b1 < cmd.cnt)
                begin
                    val_next = right_val;
                end
                // The removed element puts its value on the collection bus.
                if (pos_c == idx_c)
                begin
                    tap_next = val_reg;
                end
            end
            pl_pkg::CELL_PROBE:
            begin
                hit_next = (pos_c < cmd.cnt) && (val_reg == cmd.key);
            end
            pl_pkg::CELL_ROTATE:
            begin
                val_next = left_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tap_reg <= tap_next;
        hit_reg <= hit_next;
    end

    assign val = val_reg;
    assign tap = tap_reg;
    assign hit = hit_reg;

endmodule

// File: rtl/core/pl_chain.sv
`timescale 1ns / 1ps

module pl_chain
(
    input  logic                         clk,
    input  pl_pkg::cell_cmd_t            cmd,
    output logic [pl_pkg::DATA_W-1:0]    tail,
    output logic [pl_pkg::DATA_W-1:0]    tap_any,
    output logic                         hit_any
);

    logic [pl_pkg::DATA_W-1:0] cell_val [pl_pkg::CAPACITY];
    logic [pl_pkg::DATA_W-1:0] cell_tap [pl_pkg::CAPACITY];
    logic                      cell_hit [pl_pkg::CAPACITY];

    for (genvar g = 0; g < pl_pkg::CAPACITY; g++)
    begin : g_cell
        logic [pl_pkg::DATA_W-1:0] left_v;
        logic [pl_pkg::DATA_W-1:0] right_v;

        // The ring closes from the last cell back to the first for the dump rotation.
        if (g == 0)
        begin : g_first
            assign left_v = cell_val[pl_pkg::CAPACITY-1];
        end
        else
        begin : g_mid
            assign left_v = cell_val[g-1];
        end

        if (g == pl_pkg::CAPACITY - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_inner
            assign right_v = cell_val[g+1];
        end

        pl_cell u_cell
        (
            .clk       (clk),
            .index     (pl_pkg::IDX_W'(g)),
            .cmd       (cmd),
            .left_val  (left_v),
            .right_val (right_v),
            .val       (cell_val[g]),
            .tap       (cell_tap[g]),
            .hit       (cell_hit[g])
        );
    end

    always_comb
    begin
        tap_any = '0;
        hit_any = 1'b0;
        for (int i = 0; i < pl_pkg::CAPACITY; i++)
        begin
            tap_any = tap_any | cell_tap[i];
            hit_any = hit_any | cell_hit[i];
        end
    end

    assign tail = cell_val[pl_pkg::CAPACITY-1];

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        pl_pkg::req_t       op;
        logic [31:0]        val;
        logic [4:0]         pos;
    } list_req_t;

    typedef struct {
        pl_pkg::stat_t      st;
        logic [31:0]        dat;
        logic               hit;
        logic               fin;
        logic [4:0]         cnt;
    } list_result_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [2:0]             req_type = pl_pkg::REQ_ADD_HEAD;
    logic signed [31:0]     value = '0;
    logic [4:0]             position = '0;
    logic                   done;
    logic [1:0]             status;
    logic signed [31:0]     data;
    logic                   found;
    logic                   last;
    logic [4:0]             count;

    list_req_t              requests_to_send[$];
    list_result_t           responses_due[$];

    // Shadow copy of the list, head in slot 0.
    logic [31:0]            shadow_vals[pl_pkg::CAPACITY];
    int                     shadow_len;

    // Element count as the stimulus generator expects it, used to steer growth.
    int                     gen_len;
    int                     burst_left;
    int                     gap_left;
    int                     mismatches;

    positional_list_engine i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .data     (data),
        .found    (found),
        .last     (last),
        .count    (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void push_result(pl_pkg::stat_t st, logic [31:0] dat, logic hit,
                                        logic fin);
        list_result_t r;
        r.st  = st;
        r.dat = dat;
        r.hit = hit;
        r.fin = fin;
        r.cnt = shadow_len[4:0];
        responses_due.insert(responses_due.size(), r);
    endfunction

    // Updates the shadow list for one accepted request and queues what it must return.
    function automatic void apply_list_op(pl_pkg::req_t op, logic [31:0] v, logic [4:0] p);
        int          slot;
        int          pp;
        int          k;
        logic [31:0] taken;
        logic        hit;
        case (op)
            pl_pkg::REQ_ADD_HEAD, pl_pkg::REQ_ADD_TAIL, pl_pkg::REQ_INSERT:
            begin
                if (shadow_len >= pl_pkg::CAPACITY)
                begin
                    push_result(pl_pkg::STAT_FULL, '0, 1'b0, 1'b1);
                end
                else
                begin
                    pp = p;
                    if (pp == 0)
                        pp = 1;
                    if (pp > shadow_len + 1)
                        pp = shadow_len + 1;
                    if (op == pl_pkg::REQ_ADD_HEAD)
                        slot = 0;
                    else if (op == pl_pkg::REQ_ADD_TAIL)
                        slot = shadow_len;
                    else
                        slot = pp - 1;
                    for (k = shadow_len; k > slot; k--)
                        shadow_vals[k] = shadow_vals[k-1];
                    shadow_vals[slot] = v;
                    shadow_len++;
                    push_result(pl_pkg::STAT_OK, '0, 1'b0, 1'b1);
                end
            end
            pl_pkg::REQ_REM_HEAD, pl_pkg::REQ_REM_TAIL, pl_pkg::REQ_REM_POS:
            begin
                if (shadow_len == 0)
                begin
                    push_result(pl_pkg::STAT_EMPTY, '0, 1'b0, 1'b1);
                end
                else if (op == pl_pkg::REQ_REM_POS && (p == 0 || p > shadow_len))
                begin
                    push_result(pl_pkg::STAT_RANGE, '0, 1'b0, 1'b1);
                end
                else
                begin
                    if (op == pl_pkg::REQ_REM_HEAD)
                        slot = 0;
                    else if (op == pl_pkg::REQ_REM_TAIL)
                        slot = shadow_len - 1;
                    else
                        slot = p - 1;
                    taken = shadow_vals[slot];
                    for (k = slot; k + 1 < shadow_len; k++)
                        shadow_vals[k] = shadow_vals[k+1];
                    shadow_len--;
                    push_result(pl_pkg::STAT_OK, taken, 1'b0, 1'b1);
                end
            end
            pl_pkg::REQ_SEARCH:
            begin
                if (shadow_len == 0)
                begin
                    push_result(pl_pkg::STAT_EMPTY, '0, 1'b0, 1'b1);
                end
                else
                begin
                    hit = 1'b0;
                    for (k = 0; k < shadow_len; k++)
                        if (shadow_vals[k] == v)
                            hit = 1'b1;
                    push_result(pl_pkg::STAT_OK, '0, hit, 1'b1);
                end
            end
            default:
            begin
                if (shadow_len == 0)
                    push_result(pl_pkg::STAT_EMPTY, '0, 1'b0, 1'b1);
                else
                    for (k = shadow_len - 1; k >= 0; k--)
                        push_result(pl_pkg::STAT_OK, shadow_vals[k], 1'b0, k == 0);
            end
        endcase
    endfunction

    task automatic add_req(input pl_pkg::req_t op, input logic [31:0] v, input logic [4:0] p);
        list_req_t r;
        r.op  = op;
        r.val = v;
        r.pos = p;
        requests_to_send.insert(requests_to_send.size(), r);
        case (op)
            pl_pkg::REQ_ADD_HEAD, pl_pkg::REQ_ADD_TAIL, pl_pkg::REQ_INSERT:
                if (gen_len < pl_pkg::CAPACITY)
                    gen_len++;
            pl_pkg::REQ_REM_HEAD, pl_pkg::REQ_REM_TAIL:
                if (gen_len > 0)
                    gen_len--;
            pl_pkg::REQ_REM_POS:
                if (gen_len > 0 && p != 0 && p <= gen_len)
                    gen_len--;
            default:
                ;
        endcase
    endtask

    // Request driver: holds a request until the handshake takes it, then
    // moves on in bursts separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        list_req_t nxt;
        logic      nxt_start;
        if (!rst_n)
        begin
            start      <= 1'b0;
            burst_left  = $urandom_range(1, 12);
            gap_left    = 0;
        end
        else if (!start || !busy)
        begin
            if (start)
                apply_list_op(pl_pkg::req_t'(req_type), value, position);
            nxt_start = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (requests_to_send.size() != 0)
            begin
                nxt       = requests_to_send.pop_front();
                nxt_start = 1'b1;
                req_type <= nxt.op;
                value    <= nxt.val;
                position <= nxt.pos;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            start <= nxt_start;
        end
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && done)
        begin
            if (responses_due.size() == 0)
            begin
                report_mismatch("result strobe with no request outstanding");
            end
            else
            begin
                want = responses_due.pop_front();
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
                if (data !== want.dat)
                    report_mismatch($sformatf("data %h, wanted %h", data, want.dat));
                if (found !== want.hit)
                    report_mismatch($sformatf("found %b, wanted %b", found, want.hit));
                if (last !== want.fin)
                    report_mismatch($sformatf("last %b, wanted %b", last, want.fin));
                if (count !== want.cnt)
                    report_mismatch($sformatf("count %0d, wanted %0d", count, want.cnt));
            end
        end
    end

    initial
    begin
        int           n;
        int           r;
        bit           growing;
        pl_pkg::req_t op;
        logic [31:0]  v;
        logic [4:0]   p;

        mismatches = 0;
        shadow_len = 0;
        gen_len    = 0;
        growing    = 1'b1;

        // Every remove, search and dump request against an empty list.
        add_req(pl_pkg::REQ_REM_HEAD, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_TAIL, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd1);
        add_req(pl_pkg::REQ_SEARCH, '0, 5'd0);
        add_req(pl_pkg::REQ_DUMP, '0, 5'd0);
        // Value extremes, position zero to the front, position far past the end.
        add_req(pl_pkg::REQ_ADD_HEAD, 32'h8000_0000, 5'd0);
        add_req(pl_pkg::REQ_ADD_TAIL, 32'h7FFF_FFFF, 5'd0);
        add_req(pl_pkg::REQ_INSERT, 32'd1, 5'd0);
        add_req(pl_pkg::REQ_INSERT, 32'hFFFF_FFFF, 5'd31);
        add_req(pl_pkg::REQ_INSERT, 32'd0, 5'd2);
        add_req(pl_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 5'd0);
        add_req(pl_pkg::REQ_SEARCH, 32'd5, 5'd0);
        add_req(pl_pkg::REQ_DUMP, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd31);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd2);
        add_req(pl_pkg::REQ_REM_HEAD, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_TAIL, '0, 5'd0);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd2);
        add_req(pl_pkg::REQ_REM_POS, '0, 5'd1);
        add_req(pl_pkg::REQ_DUMP, '0, 5'd0);

        // Random part alternates between filling to capacity and draining to empty.
        for (n = 0; n < 90; n++)
        begin
            if (growing && gen_len == pl_pkg::CAPACITY && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (!growing && gen_len == 0 && $urandom_range(0, 2) == 0)
                growing = 1'b1;
            r = $urandom_range(0, 99);
            v = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 9);
            p = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, gen_len + 1));
            if (r < 10)
                op = pl_pkg::req_t'(3'($urandom_range(0, 7)));
            else if (r < (growing ? 70 : 25))
                op = pl_pkg::req_t'(3'($urandom_range(pl_pkg::REQ_ADD_HEAD,
                                                      pl_pkg::REQ_INSERT)));
            else if (r < 85)
                op = pl_pkg::req_t'(3'($urandom_range(pl_pkg::REQ_REM_HEAD,
                                                      pl_pkg::REQ_REM_POS)));
            else if (r < 93)
                op = pl_pkg::REQ_SEARCH;
            else
                op = pl_pkg::REQ_DUMP;
            add_req(op, v, p);
        end

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (requests_to_send.size() != 0 || start || responses_due.size() != 0)
            @(negedge clk);
        repeat (pl_pkg::CAPACITY + 8) @(negedge clk);

        if (responses_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", responses_due.size()));
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
